// ===== design/rfr_pkg.sv =====
// Shared types and constants for the radio frame receiver.
package rfr_pkg;

  localparam logic [7:0] START_BYTE       = 8'hFF;
  localparam logic [7:0] SUM_MODULUS      = 8'd255;
  localparam logic [7:0] LENGTH_LIMIT_RST = 8'd114;

  // Configuration register indexes
  localparam logic [2:0] REG_OWN_ID          = 3'd0;
  localparam logic [2:0] REG_PARTNER_ID      = 3'd1;
  localparam logic [2:0] REG_HANDSHAKE_CODE  = 3'd2;
  localparam logic [2:0] REG_CLOCK_SYNC_CODE = 3'd3;
  localparam logic [2:0] REG_LENGTH_LIMIT    = 3'd4;

  // Frame status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_BAD_SUM        = 3'd1;
  localparam logic [2:0] ST_WRONG_SENDER   = 3'd2;
  localparam logic [2:0] ST_WRONG_RECEIVER = 3'd3;
  localparam logic [2:0] ST_TOO_LONG       = 3'd4;

  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_STATUS  = 1'b1;

  typedef struct packed {
    logic [7:0] own_id;
    logic [7:0] partner_id;
    logic [7:0] handshake_code;
    logic [7:0] clock_sync_code;
    logic [7:0] length_limit;
  } cfg_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic [7:0] command_code;
    logic [2:0] frame_status;
    logic       frame_last;
  } res_t;

  // Sum of two bytes mod 255; acc is already below 255.
  function automatic logic [7:0] add_mod255(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    if (s >= {1'b0, SUM_MODULUS}) begin
      s = s - {1'b0, SUM_MODULUS};
    end
    return s[7:0];
  endfunction

endpackage

// ===== design/rfr_cfg.sv =====
// Configuration register file of the radio frame receiver.
module rfr_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output rfr_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id          <= '0;
      cfg.partner_id      <= '0;
      cfg.handshake_code  <= '0;
      cfg.clock_sync_code <= '0;
      cfg.length_limit    <= rfr_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rfr_pkg::REG_OWN_ID:          cfg.own_id          <= cfg_data;
        rfr_pkg::REG_PARTNER_ID:      cfg.partner_id      <= cfg_data;
        rfr_pkg::REG_HANDSHAKE_CODE:  cfg.handshake_code  <= cfg_data;
        rfr_pkg::REG_CLOCK_SYNC_CODE: cfg.clock_sync_code <= cfg_data;
        rfr_pkg::REG_LENGTH_LIMIT:    cfg.length_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rfr_parse.sv =====
// Input register and frame parser: one byte per cycle while out_free.
module rfr_parse (
  input  logic              clk,
  input  logic              rst,
  input  rfr_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              out_free,
  output logic              res_load,
  output rfr_pkg::res_t     res
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_SENDER   = 3'd1;
  localparam logic [2:0] PH_RECEIVER = 3'd2;
  localparam logic [2:0] PH_LENGTH   = 3'd3;
  localparam logic [2:0] PH_COMMAND  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD  = 3'd5;
  localparam logic [2:0] PH_CHECK    = 3'd6;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       fire;

  logic [2:0] phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] header_length, header_length_next;
  logic [7:0] byte_counter, byte_counter_next;
  logic       sender_match, sender_match_next;
  logic       receiver_match, receiver_match_next;
  logic [7:0] held_command, held_command_next;
  logic       link_opened, link_opened_next;

  logic       emit;
  logic       opener;
  logic [7:0] sum_add;
  logic [7:0] cnt_inc;
  logic [2:0] status;

  assign fire     = hold_valid && out_free;
  assign in_ready = !hold_valid || fire;
  assign res_load = fire && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= in_byte;
    end
  end

  assign sum_add = rfr_pkg::add_mod255(running_sum, hold_byte);
  assign cnt_inc = byte_counter + 8'd1;
  assign opener  = (held_command == cfg.handshake_code) ||
                   (held_command == cfg.clock_sync_code);

  // Sender and receiver checks outrank length, which outranks the checksum.
  always_comb begin
    if (!sender_match) begin
      status = rfr_pkg::ST_WRONG_SENDER;
    end else if (!receiver_match) begin
      status = rfr_pkg::ST_WRONG_RECEIVER;
    end else if (header_length > cfg.length_limit) begin
      status = rfr_pkg::ST_TOO_LONG;
    end else if (running_sum != hold_byte) begin
      status = rfr_pkg::ST_BAD_SUM;
    end else begin
      status = rfr_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    header_length_next  = header_length;
    byte_counter_next   = byte_counter;
    sender_match_next   = sender_match;
    receiver_match_next = receiver_match;
    held_command_next   = held_command;
    link_opened_next    = link_opened;
    emit                = 1'b0;
    res                 = '0;
    case (phase)
      PH_IDLE: begin
        if (hold_byte == rfr_pkg::START_BYTE) begin
          running_sum_next    = rfr_pkg::add_mod255(8'd0, hold_byte);
          header_length_next  = '0;
          byte_counter_next   = '0;
          sender_match_next   = 1'b0;
          receiver_match_next = 1'b0;
          held_command_next   = '0;
          phase_next          = PH_SENDER;
        end
      end
      PH_SENDER: begin
        sender_match_next = (hold_byte == cfg.partner_id);
        running_sum_next  = sum_add;
        phase_next        = PH_RECEIVER;
      end
      PH_RECEIVER: begin
        receiver_match_next = (hold_byte == cfg.own_id);
        running_sum_next    = sum_add;
        phase_next          = PH_LENGTH;
      end
      PH_LENGTH: begin
        header_length_next = hold_byte;
        running_sum_next   = sum_add;
        phase_next         = PH_COMMAND;
      end
      PH_COMMAND: begin
        held_command_next = hold_byte;
        running_sum_next  = sum_add;
        byte_counter_next = '0;
        phase_next        = (header_length == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        emit              = 1'b1;
        res.item_kind     = rfr_pkg::ITEM_PAYLOAD;
        res.payload_byte  = hold_byte;
        res.payload_index = byte_counter;
        running_sum_next  = sum_add;
        byte_counter_next = cnt_inc;
        if (cnt_inc == header_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        emit             = 1'b1;
        res.item_kind    = rfr_pkg::ITEM_STATUS;
        res.frame_length = header_length;
        res.command_code = (link_opened || opener) ? held_command : 8'd0;
        res.frame_status = status;
        res.frame_last   = 1'b1;
        if (status == rfr_pkg::ST_OK && opener) begin
          link_opened_next = 1'b1;
        end
        phase_next        = PH_IDLE;
        running_sum_next  = '0;
        byte_counter_next = '0;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      running_sum    <= '0;
      header_length  <= '0;
      byte_counter   <= '0;
      sender_match   <= 1'b0;
      receiver_match <= 1'b0;
      held_command   <= '0;
      link_opened    <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      header_length  <= header_length_next;
      byte_counter   <= byte_counter_next;
      sender_match   <= sender_match_next;
      receiver_match <= receiver_match_next;
      held_command   <= held_command_next;
      link_opened    <= link_opened_next;
    end
  end

endmodule

// ===== design/rfr_out.sv =====
// Result register driving the master-side stream.
module rfr_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_load,
  input  rfr_pkg::res_t     res,
  output logic              out_free,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  output logic              m_axis_tuser
);

  rfr_pkg::res_t res_q;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {5'd0, res_q.frame_status, res_q.command_code,
                         res_q.frame_length, res_q.payload_index, res_q.payload_byte};
  assign m_axis_tlast = res_q.frame_last;
  assign m_axis_tuser = res_q.item_kind;

endmodule

// ===== design/radio_frame_receiver_core.sv =====
// Radio frame receiver top level: config registers, parser and result register.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: rx_byte
//  m_axis    out  m_axis_tvalid/tready        tdata, tlast, tuser (see ports)
//  cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// One byte per cycle sustained while m_axis does not stall; an accepted
// byte is held in the input register, then its result in the result register.
// Header bytes and idle bytes give no result beat.
// Synchronous reset clears the parser state, the link flag and both valids.
// A stalled m_axis holds the result register, which in turn holds the input
// register; s_axis_tready drops only once both are full.
module radio_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                      // [23:16] frame_length, [31:24] command_code,
                                      // [34:32] frame_status, [39:35] zero
  output logic        m_axis_tlast,   // frame_last
  output logic        m_axis_tuser,   // item_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  rfr_pkg::cfg_t cfg;
  rfr_pkg::res_t res;
  logic          res_load;
  logic          out_free;

  rfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfr_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  rfr_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res_load      (res_load),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
